[hw/rtl/clws_pkg.sv]
// Package for the character LCD write sequencer: widths, codes, microcode word and program ROM.
package clws_pkg;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;
    localparam int WAIT_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int PC_W       = 5;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] OP_COMMAND = 2'd0;
    localparam logic [1:0] OP_DATA    = 2'd1;
    localparam logic [1:0] OP_CURSOR  = 2'd2;
    localparam logic [1:0] OP_INIT    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_FOUR_BIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP_TICKS = 2'd2;

    localparam logic [WAIT_W-1:0] POWER_UP_TICKS_RESET = 20'd50000;
    localparam logic [WAIT_W-1:0] LONG_INIT_WAIT       = 20'd5000;
    localparam logic [WAIT_W-1:0] SHORT_INIT_WAIT      = 20'd500;
    localparam logic [7:0]        DDRAM_ADDR_FLAG      = 8'd128;

    // Program entry points.
    localparam logic [PC_W-1:0] UC_BYTE  = 5'd0;
    localparam logic [PC_W-1:0] UC_NIB   = 5'd1;
    localparam logic [PC_W-1:0] UC_INIT4 = 5'd3;
    localparam logic [PC_W-1:0] UC_INIT8 = 5'd19;
    localparam logic [PC_W-1:0] UC_END   = 5'd26;

    typedef enum logic [1:0] {
        BUS_CONST,
        BUS_BYTE,
        BUS_HIGH,
        BUS_LOW
    } bus_sel_t;

    typedef enum logic [1:0] {
        WAIT_ZERO,
        WAIT_POWER_UP,
        WAIT_LONG,
        WAIT_SHORT
    } wait_sel_t;

    typedef struct packed {
        logic [7:0] konst;
        bus_sel_t   bus_sel;
        wait_sel_t  wait_sel;
        logic       last;
    } uc_word_t;

    function automatic uc_word_t uc_make(input logic [7:0] k, input bus_sel_t b,
                                         input wait_sel_t w, input logic l);
        uc_word_t u;
        u.konst    = k;
        u.bus_sel  = b;
        u.wait_sel = w;
        u.last     = l;
        return u;
    endfunction

    function automatic uc_word_t uc_rom(input logic [PC_W-1:0] addr);
        uc_word_t u;
        case (addr)
            5'd0:    u = uc_make(8'h00, BUS_BYTE,  WAIT_ZERO,     1'b1);
            5'd1:    u = uc_make(8'h00, BUS_HIGH,  WAIT_ZERO,     1'b0);
            5'd2:    u = uc_make(8'h00, BUS_LOW,   WAIT_ZERO,     1'b1);
            // Four-bit power-up program.
            5'd3:    u = uc_make(8'h03, BUS_CONST, WAIT_POWER_UP, 1'b0);
            5'd4:    u = uc_make(8'h03, BUS_CONST, WAIT_LONG,     1'b0);
            5'd5:    u = uc_make(8'h03, BUS_CONST, WAIT_SHORT,    1'b0);
            5'd6:    u = uc_make(8'h02, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd7:    u = uc_make(8'h02, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd8:    u = uc_make(8'h0C, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd9:    u = uc_make(8'h00, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd10:   u = uc_make(8'h08, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd11:   u = uc_make(8'h00, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd12:   u = uc_make(8'h01, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd13:   u = uc_make(8'h00, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd14:   u = uc_make(8'h06, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd15:   u = uc_make(8'h00, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd16:   u = uc_make(8'h0C, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd17:   u = uc_make(8'h00, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd18:   u = uc_make(8'h01, BUS_CONST, WAIT_ZERO,     1'b1);
            // Eight-bit power-up program.
            5'd19:   u = uc_make(8'h30, BUS_CONST, WAIT_POWER_UP, 1'b0);
            5'd20:   u = uc_make(8'h30, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd21:   u = uc_make(8'h30, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd22:   u = uc_make(8'h38, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd23:   u = uc_make(8'h08, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd24:   u = uc_make(8'h01, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd25:   u = uc_make(8'h06, BUS_CONST, WAIT_ZERO,     1'b0);
            5'd26:   u = uc_make(8'h0C, BUS_CONST, WAIT_ZERO,     1'b1);
            default: u = uc_make(8'h00, BUS_BYTE,  WAIT_ZERO,     1'b1);
        endcase
        return u;
    endfunction

    function automatic logic [7:0] row_offset(input logic [1:0] row);
        logic [7:0] r;
        case (row)
            2'd0:    r = 8'h00;
            2'd1:    r = 8'h40;
            2'd2:    r = 8'h14;
            default: r = 8'h54;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/char_lcd_write_sequencer_core.sv]
// Character LCD write sequencer: microcoded strobe generator with output register.
//
//  channel | direction | handshake                  | payload
//  s_axis  | in        | s_axis_tvalid/s_axis_tready | tdata {column,row,value}, tuser op
//  m_axis  | out       | m_axis_tvalid/m_axis_tready | tdata {0,wait_before,bus_value},
//          |           |                            | tuser reg_select, tlast last
//  cfg     | in        | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// A request is registered on entry, then the step counter walks the program ROM, one microcode
// step per strobe: one strobe for a byte in 8-bit mode, two in 4-bit mode, eight or sixteen
// for init. Reset leaves the block idle in 4-bit mode.
// A stalled output holds the step counter; a new request is taken once the last strobe of
// the previous one sits in the output register.
module char_lcd_write_sequencer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [clws_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // value[7:0], row[9:8], column[15:10]
    input  logic [clws_pkg::IN_USER_W-1:0]    s_axis_tuser,  // op[1:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [clws_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // bus_value[7:0], wait_before[27:8]
    output logic                              m_axis_tuser,  // reg_select
    output logic                              m_axis_tlast,  // last
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [clws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clws_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import clws_pkg::*;

    logic                  bus_four_bit_reg;
    logic [WAIT_W-1:0]     power_up_ticks_reg;
    logic                  busy_reg;
    logic [PC_W-1:0]       pc_reg;
    logic [7:0]            byte_reg;
    logic                  rs_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tuser_reg;
    logic                  m_tlast_reg;

    uc_word_t              uc;
    logic                  in_accept;
    logic                  step;
    logic [7:0]            bus_next;
    logic [WAIT_W-1:0]     wait_next;
    logic [PC_W-1:0]       entry;
    logic [7:0]            byte_next;
    logic [1:0]            op_in;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy_reg;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;
    assign m_axis_tlast  = m_tlast_reg;

    assign in_accept = s_axis_tvalid && !busy_reg;
    assign step      = busy_reg && (!m_tvalid_reg || m_axis_tready);
    assign uc        = uc_rom(pc_reg);
    assign op_in     = s_axis_tuser;

    // Dispatch: kind and bus width pick the program entry; a cursor yields its DDRAM address.
    always_comb
    begin
        case (op_in)
            OP_INIT: entry = bus_four_bit_reg ? UC_INIT4 : UC_INIT8;
            default: entry = bus_four_bit_reg ? UC_NIB : UC_BYTE;
        endcase
        if (op_in == OP_CURSOR)
            byte_next = {2'b00, s_axis_tdata[15:10]} + row_offset(s_axis_tdata[9:8])
                        + DDRAM_ADDR_FLAG;
        else
            byte_next = s_axis_tdata[7:0];
    end

    always_comb
    begin
        case (uc.bus_sel)
            BUS_CONST: bus_next = uc.konst;
            BUS_BYTE:  bus_next = byte_reg;
            BUS_HIGH:  bus_next = {4'h0, byte_reg[7:4]};
            BUS_LOW:   bus_next = {4'h0, byte_reg[3:0]};
            default:   bus_next = byte_reg;
        endcase
        case (uc.wait_sel)
            WAIT_ZERO:     wait_next = '0;
            WAIT_POWER_UP: wait_next = power_up_ticks_reg;
            WAIT_LONG:     wait_next = LONG_INIT_WAIT;
            WAIT_SHORT:    wait_next = SHORT_INIT_WAIT;
            default:       wait_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_four_bit_reg   <= 1'b1;
            power_up_ticks_reg <= POWER_UP_TICKS_RESET;
            busy_reg           <= 1'b0;
            pc_reg             <= UC_BYTE;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            // The enable time belongs to the strobe driver and is not kept here.
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_BUS_FOUR_BIT:   bus_four_bit_reg   <= cfg_data[0];
                    CFG_POWER_UP_TICKS: power_up_ticks_reg <= cfg_data;
                    default:            ;
                endcase
            end
            if (in_accept)
            begin
                busy_reg <= 1'b1;
                pc_reg   <= entry;
            end
            else if (step)
            begin
                busy_reg <= !uc.last;
                pc_reg   <= pc_reg + 5'd1;
            end
            if (step)
                m_tvalid_reg <= 1'b1;
            else if (m_axis_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= byte_next;
            rs_reg   <= (op_in == OP_DATA);
        end
        if (step)
        begin
            m_tdata_reg <= {4'h0, wait_next, bus_next};
            m_tuser_reg <= (uc.bus_sel == BUS_CONST) ? 1'b0 : rs_reg;
            m_tlast_reg <= uc.last;
        end
    end

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= UC_END)
        else $error("step counter left the program");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> busy_reg && !s_axis_tready)
        else $error("request accepted without starting the program");

    a_nibble_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        step && (uc.bus_sel == BUS_HIGH || uc.bus_sel == BUS_LOW)
        |=> m_tdata_reg[7:4] == 4'h0)
        else $error("nibble strobe carries upper bits");

    a_data_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_tuser_reg |-> m_tdata_reg[27:8] == '0)
        else $error("data strobe carries a wait");

endmodule

[tb/tb_char_lcd_write_sequencer_core.sv]
// Self-checking testbench for the character LCD write sequencer core.
module tb_char_lcd_write_sequencer_core;

    import clws_pkg::*;

    localparam int             CYCLE_LIMIT      = 600000;
    localparam int             RX_HOLD_CYCLES   = 300;
    localparam int             TAIL_CYCLES      = 40;
    localparam int             ITEMS_PER_PHASE  = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic              reg_sel;
        logic [7:0]        bus;
        logic [WAIT_W-1:0] wait_ticks;
        logic              is_last;
    } strobe_t;

    // Predicts the strobes of each request and checks the block's output against them.
    class lcd_strobe_board;
        strobe_t           pending[$];
        logic              four_bit;
        logic [15:0]       enable_len;
        logic [WAIT_W-1:0] power_up;
        int                errors;
        int                reported;
        logic [7:0]        line_base[4];
        logic [3:0]        init_nibbles4[16];
        logic [7:0]        init_bytes8[8];

        function new();
            four_bit      = 1'b1;
            enable_len    = 16'd5000;
            power_up      = POWER_UP_TICKS_RESET;
            errors        = 0;
            reported      = 0;
            line_base     = '{8'h00, 8'h40, 8'h14, 8'h54};
            init_nibbles4 = '{4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'hC, 4'h0, 4'h8,
                              4'h0, 4'h1, 4'h0, 4'h6, 4'h0, 4'hC, 4'h0, 4'h1};
            init_bytes8   = '{8'h30, 8'h30, 8'h30, 8'h38, 8'h08, 8'h01, 8'h06, 8'h0C};
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_BUS_FOUR_BIT:   four_bit   = data[0];
                CFG_ENABLE_TICKS:   enable_len = data[15:0];
                CFG_POWER_UP_TICKS: power_up   = data[WAIT_W-1:0];
                default:            ;
            endcase
        endfunction

        function void add_strobe(logic rs, logic [7:0] bus, logic [WAIT_W-1:0] ticks,
                                 logic tail);
            strobe_t s;
            s.reg_sel    = rs;
            s.bus        = bus;
            s.wait_ticks = ticks;
            s.is_last    = tail;
            pending.push_back(s);
        endfunction

        function void queue_byte(logic rs, logic [7:0] byte_val);
            if (four_bit)
            begin
                add_strobe(rs, {4'h0, byte_val[7:4]}, '0, 1'b0);
                add_strobe(rs, {4'h0, byte_val[3:0]}, '0, 1'b1);
            end
            else
            begin
                add_strobe(rs, byte_val, '0, 1'b1);
            end
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] value, logic [1:0] row,
                                   logic [5:0] column);
            logic [7:0]        addr;
            logic [WAIT_W-1:0] ticks;
            case (op)
                OP_COMMAND: queue_byte(1'b0, value);
                OP_DATA:    queue_byte(1'b1, value);
                OP_CURSOR:
                begin
                    // The DDRAM address wraps at eight bits for columns past the line.
                    addr = {2'b00, column} + line_base[row] + DDRAM_ADDR_FLAG;
                    queue_byte(1'b0, addr);
                end
                default:
                begin
                    if (four_bit)
                    begin
                        for (int i = 0; i < 16; i++)
                        begin
                            case (i)
                                0:       ticks = power_up;
                                1:       ticks = LONG_INIT_WAIT;
                                2:       ticks = SHORT_INIT_WAIT;
                                default: ticks = '0;
                            endcase
                            add_strobe(1'b0, {4'h0, init_nibbles4[i]}, ticks, i == 15);
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < 8; i++)
                            add_strobe(1'b0, init_bytes8[i], (i == 0) ? power_up : '0, i == 7);
                    end
                end
            endcase
        endfunction

        function void check_strobe(strobe_t got);
            strobe_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected strobe: rs=%0d bus=%h wait=%0d last=%0d",
                             got.reg_sel, got.bus, got.wait_ticks, got.is_last);
                end
                return;
            end
            want = pending.pop_front();
            if (got.reg_sel !== want.reg_sel || got.bus !== want.bus ||
                got.wait_ticks !== want.wait_ticks || got.is_last !== want.is_last)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $write("strobe mismatch: expected rs=%0d bus=%h wait=%0d last=%0d, ",
                           want.reg_sel, want.bus, want.wait_ticks, want.is_last);
                    $display("got rs=%0d bus=%h wait=%0d last=%0d",
                             got.reg_sel, got.bus, got.wait_ticks, got.is_last);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lcd_strobe_board board;
    int              tx_idle_pct = 0;
    int              rx_idle_pct = 0;
    logic            rx_hold_pending = 1'b0;
    int              cycle_count = 0;

    char_lcd_write_sequencer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("char_lcd_write_sequencer_core regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        strobe_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.reg_sel    = m_axis_tuser;
            got.bus        = m_axis_tdata[7:0];
            got.wait_ticks = m_axis_tdata[27:8];
            got.is_last    = m_axis_tlast;
            board.check_strobe(got);
        end
    end

    // Output back-pressure: random stall bursts, and one long hold-off on request.
    initial
    begin
        int   gap;
        logic hold_done;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold_pending && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 99) < rx_idle_pct)
            begin
                m_axis_tready <= 1'b0;
                gap = $urandom_range(1, 17);
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Leaves tvalid high after acceptance so that back-to-back requests need no dip.
    task automatic send_request(logic [1:0] op, logic [7:0] value, logic [1:0] row,
                                logic [5:0] column);
        int gap;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {column, row, value};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        board.note_request(op, value, row, column);
    endtask

    task automatic send_random_request();
        logic [1:0] op;
        logic [5:0] column;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            op = OP_INIT;
        else if (pick < 40)
            op = OP_COMMAND;
        else if (pick < 70)
            op = OP_DATA;
        else
            op = OP_CURSOR;
        if ($urandom_range(0, 99) < 85)
            column = 6'($urandom_range(0, 39));
        else
            column = 6'($urandom_range(40, 63));
        send_request(op, 8'($urandom), 2'($urandom), column);
    endtask

    task automatic drain_requests();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(index, data);
    endtask

    task automatic randomise_config();
        logic [CFG_DATA_W-1:0] pu;
        case ($urandom_range(0, 3))
            0:       pu = '0;
            1:       pu = '1;
            default: pu = CFG_DATA_W'($urandom);
        endcase
        write_reg(CFG_BUS_FOUR_BIT, CFG_DATA_W'($urandom));
        write_reg(CFG_ENABLE_TICKS, CFG_DATA_W'($urandom));
        write_reg(CFG_POWER_UP_TICKS, pu);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        board = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_COMMAND;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_BUS_FOUR_BIT;
        cfg_data      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 4-bit bus, default power-up wait.
        tx_idle_pct = 20;
        rx_idle_pct = 10;
        send_request(OP_COMMAND, 8'h00, 2'd0, 6'd0);
        send_request(OP_DATA,    8'hFF, 2'd3, 6'd63);
        send_request(OP_DATA,    8'hA5, 2'd1, 6'd21);
        send_request(OP_CURSOR,  8'hFF, 2'd0, 6'd0);
        send_request(OP_CURSOR,  8'h00, 2'd1, 6'd39);
        send_request(OP_CURSOR,  8'h5A, 2'd2, 6'd63);
        send_request(OP_CURSOR,  8'h00, 2'd3, 6'd63);
        send_request(OP_INIT,    8'hFF, 2'd3, 6'd63);
        drain_requests();

        // 8-bit bus with the longest power-up wait.
        write_reg(CFG_BUS_FOUR_BIT, 20'hFFFFE);
        write_reg(CFG_ENABLE_TICKS, '0);
        write_reg(CFG_POWER_UP_TICKS, '1);
        cfg_valid <= 1'b0;
        send_request(OP_COMMAND, 8'hFF, 2'd2, 6'd17);
        send_request(OP_DATA,    8'h00, 2'd1, 6'd5);
        send_request(OP_CURSOR,  8'h33, 2'd3, 6'd44);
        send_request(OP_CURSOR,  8'hCC, 2'd1, 6'd5);
        send_request(OP_INIT,    8'h81, 2'd2, 6'd42);
        send_request(OP_DATA,    8'h7E, 2'd0, 6'd0);
        drain_requests();

        // Index outside the register map must leave the settings alone.
        write_reg(CFG_UNUSED_INDEX, '1);
        write_reg(CFG_BUS_FOUR_BIT, 20'd1);
        write_reg(CFG_ENABLE_TICKS, 20'hFFFFF);
        write_reg(CFG_POWER_UP_TICKS, '0);
        cfg_valid <= 1'b0;
        send_request(OP_INIT,    8'h00, 2'd0, 6'd0);
        send_request(OP_DATA,    8'h5A, 2'd2, 6'd30);
        send_request(OP_COMMAND, 8'h96, 2'd1, 6'd12);
        send_request(OP_CURSOR,  8'h00, 2'd2, 6'd39);
        drain_requests();

        for (int phase = 0; phase < 4; phase++)
        begin
            randomise_config();
            case (phase)
                0:
                begin
                    tx_idle_pct = 30;
                    rx_idle_pct = 15;
                end
                1:
                begin
                    // Output held off while requests keep coming, so the input backs up.
                    tx_idle_pct = 0;
                    rx_idle_pct = 15;
                    rx_hold_pending = 1'b1;
                    for (int n = 0; n < 12; n++)
                        send_random_request();
                    tx_idle_pct = 30;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 20;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_random_request();
                if (phase == 2 && n == ITEMS_PER_PHASE / 2)
                    drain_requests();
            end
            drain_requests();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("char_lcd_write_sequencer_core regression: pass");
        else
            $display("char_lcd_write_sequencer_core regression: fail");
        $finish;
    end

endmodule
